### design/shadow_silhouette_extruder_defines.svh
// Assertion macros used by the checker file, sse_checker.sv.
`ifndef SHADOW_SILHOUETTE_EXTRUDER_DEFINES_SVH
`define SHADOW_SILHOUETTE_EXTRUDER_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, off while in reset.
`define SSE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off while in reset.
`define SSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/sse_pkg.sv
// Shared types and constants of the shadow silhouette extruder.
package sse_pkg;

  localparam int unsigned CoordBits   = 16;
  localparam int unsigned MaxVertices = 32;
  localparam int unsigned AddrBits    = $clog2(MaxVertices);
  localparam int unsigned CntBits     = $clog2(MaxVertices + 1);
  localparam int unsigned CfgIdxBits  = 2;
  // Edge math: differences, doubled light minus two vertices, dot products.
  localparam int unsigned EdgeBits    = CoordBits + 2;
  localparam int unsigned ProdBits    = 2 * EdgeBits;
  // Walk math.
  localparam int unsigned DiffBits    = CoordBits + 1;
  localparam int unsigned SqBits      = 2 * DiffBits;
  localparam int unsigned ScaleBits   = 8;                    // extra fraction bits of length
  localparam int unsigned RootBits    = (SqBits + 2 * ScaleBits + 1) / 2;
  localparam int unsigned MulBits     = DiffBits + CoordBits;
  localparam int unsigned NumBits     = MulBits + ScaleBits + 1;
  localparam int unsigned FarBits     = NumBits + 1;
  localparam int unsigned IterBits    = $clog2(NumBits + 1);

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_LIGHT_X      = 2'd0,
    CFG_LIGHT_Y      = 2'd1,
    CFG_LIGHT_RADIUS = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SCAN_RD,
    ST_SCAN_MUL,
    ST_SCAN_SUM,
    ST_SPAN,
    ST_WALK_RD,
    ST_WALK_D,
    ST_WALK_SQ,
    ST_WALK_Q,
    ST_SQRT,
    ST_DINIT,
    ST_DIV,
    ST_FAR,
    ST_PUT,
    ST_EMPTY
  } state_e;

  typedef struct packed {
    logic signed [CoordBits-1:0] vertex_x;
    logic signed [CoordBits-1:0] vertex_y;
    logic                        last_vertex;
  } vtx_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] near_x;
    logic signed [CoordBits-1:0] near_y;
    logic signed [CoordBits-1:0] far_x;
    logic signed [CoordBits-1:0] far_y;
    logic                        has_shadow;
    logic                        far_clipped;
    logic                        too_many_vertices;
    logic                        last_pair;
  } res_t;

endpackage

### design/sse_if.sv
// Valid/ready channels for vertex input beats and result beats.
interface sse_vtx_if;
  logic          valid;
  logic          ready;
  sse_pkg::vtx_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sse_res_if;
  logic          valid;
  logic          ready;
  sse_pkg::res_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### design/sse_ram.sv
// Generic single-port RAM with registered read.
module sse_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

### design/shadow_silhouette_extruder.sv
// Shadow silhouette extruder: top level, vertex store and edge/walk sequencer.
//
// Vertices of a closed polygon enter one beat per cycle on vtx_i and are kept
// in a 32-entry RAM; the beat with last_vertex set closes the polygon. Beyond
// 32 vertices beats are accepted but dropped, and every result of that polygon
// carries too_many_vertices. The sequencer then scans the edges through the
// RAM, tests each edge for facing the light, and keeps the last front-to-back
// and back-to-front change. It then walks the vertices from the entry change
// to the exit change, wrapping, and gives one result beat per vertex: the
// vertex and the vertex pushed away from the light by light_radius along the
// unit ray, saturated to Q12.4 with far_clipped set. For each vertex a 25-step
// bit-serial square root of the squared distance is followed by a 42-step
// restoring divide (x and y in parallel); a vertex on the light skips both.
// With no silhouette there is a single beat with has_shadow low. The last
// result is held in an output register, so the next polygon can load while
// it waits. No input is taken during the scan and walk. Light position and
// radius are written through cfg_we_i/cfg_idx_i/cfg_data_i, only while the
// block is idle; the user must keep to that, the block does not enforce it.
module shadow_silhouette_extruder (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [sse_pkg::CfgIdxBits-1:0]   cfg_idx_i,
  input  logic [sse_pkg::CoordBits-1:0]    cfg_data_i,
  sse_vtx_if.sink                          vtx_i,
  sse_res_if.source                        res_o
);
  localparam int unsigned CB = sse_pkg::CoordBits;
  localparam int unsigned EB = sse_pkg::EdgeBits;
  localparam int unsigned PB = sse_pkg::ProdBits;
  localparam int unsigned DB = sse_pkg::DiffBits;
  localparam int unsigned SB = sse_pkg::SqBits;
  localparam int unsigned RB = sse_pkg::RootBits;
  localparam int unsigned NB = sse_pkg::NumBits;
  localparam int unsigned FB = sse_pkg::FarBits;
  localparam int unsigned AB = sse_pkg::AddrBits;
  localparam int unsigned NC = sse_pkg::CntBits;
  localparam int unsigned IB = sse_pkg::IterBits;
  localparam logic signed [FB-1:0] CoordMax = FB'((64'sd1 <<< (CB - 1)) - 64'sd1);
  localparam logic signed [FB-1:0] CoordMin = -CoordMax - FB'(1);

  // ---------------------------------------------------------------- state
  sse_pkg::state_e state_q, state_d;

  logic signed [CB-1:0] lx_q, ly_q;          // light position
  logic        [CB-1:0] lr_q;                // light radius
  logic [NC-1:0]        cnt_q, cnt_d;        // stored vertices
  logic                 ovf_q, ovf_d;        // dropped vertices seen

  // Edge scan
  logic [NC-1:0]        idx_q, idx_d;
  logic signed [CB-1:0] px_q, px_d, py_q, py_d;
  logic signed [PB-1:0] p1_q, p1_d, p2_q, p2_d;
  logic                 f0_q, f0_d, fprev_q, fprev_d;
  logic [AB-1:0]        ent_q, ent_d, ext_q, ext_d;
  logic [1:0]           found_q, found_d;

  // Walk
  logic [AB-1:0]        widx_q, widx_d, k_q, k_d, span_q, span_d;
  logic signed [CB-1:0] vx_q, vx_d, vy_q, vy_d;
  logic signed [DB-1:0] dx_q, dx_d, dy_q, dy_d;
  logic [SB-1:0]        sqx_q, sqx_d, sqy_q, sqy_d;
  logic [2*RB-1:0]      sv_q, sv_d;          // radicand, two bits a step
  logic [RB:0]          srem_q, srem_d;
  logic [RB-1:0]        root_q, root_d;
  logic [IB-1:0]        it_q, it_d;
  logic [sse_pkg::MulBits-1:0] mx_q, mx_d, my_q, my_d;
  logic [NB-1:0]        nx_q, nx_d, ny_q, ny_d;   // dividend, becomes quotient
  logic [RB-1:0]        rx_q, rx_d, ry_q, ry_d;
  logic signed [CB-1:0] fx_q, fx_d, fy_q, fy_d;
  logic                 clip_q, clip_d;

  // Output register
  sse_pkg::res_t        out_q, out_d;
  logic                 out_valid_q, out_valid_d;

  // RAM
  logic                 ram_we;
  logic [AB-1:0]        ram_addr;
  logic [2*CB-1:0]      ram_rdata;

  sse_ram #(.WIDTH(2 * CB), .DEPTH(sse_pkg::MaxVertices)) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i ({vtx_i.data.vertex_x, vtx_i.data.vertex_y}),
    .rdata_o (ram_rdata)
  );

  assign vtx_i.ready = (state_q == sse_pkg::ST_LOAD);
  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_q;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lx_q <= '0;
      ly_q <= '0;
      lr_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sse_pkg::CFG_LIGHT_X:      lx_q <= cfg_data_i;
        sse_pkg::CFG_LIGHT_Y:      ly_q <= cfg_data_i;
        sse_pkg::CFG_LIGHT_RADIUS: lr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    logic                 acc, fnow, f0v, put_ok;
    logic signed [CB-1:0] cx, cy;
    logic signed [EB-1:0] ex_n, ex_l, ey_n, ey_l;
    logic signed [PB:0]   dot;
    logic [AB-1:0]        e;
    logic [NC:0]          sp;
    logic [RB+2:0]        rem2;
    logic [RB+2:0]        trial;
    logic [RB:0]          drx, dry;
    logic                 bx, by;
    logic signed [FB-1:0] ox, oy, sx, sy;
    logic [SB:0]          qsum;
    logic [NC-1:0]        wnext;

    state_d  = state_q;
    cnt_d    = cnt_q;    ovf_d   = ovf_q;
    idx_d    = idx_q;    px_d    = px_q;    py_d = py_q;
    p1_d     = p1_q;     p2_d    = p2_q;
    f0_d     = f0_q;     fprev_d = fprev_q;
    ent_d    = ent_q;    ext_d   = ext_q;   found_d = found_q;
    widx_d   = widx_q;   k_d     = k_q;     span_d  = span_q;
    vx_d     = vx_q;     vy_d    = vy_q;    dx_d = dx_q;  dy_d = dy_q;
    sqx_d    = sqx_q;    sqy_d   = sqy_q;
    sv_d     = sv_q;     srem_d  = srem_q;  root_d = root_q; it_d = it_q;
    mx_d     = mx_q;     my_d    = my_q;
    nx_d     = nx_q;     ny_d    = ny_q;    rx_d = rx_q;  ry_d = ry_q;
    fx_d     = fx_q;     fy_d    = fy_q;    clip_d = clip_q;
    out_d    = out_q;
    out_valid_d = out_valid_q && !res_o.ready;
    put_ok   = !out_valid_q || res_o.ready;

    acc      = vtx_i.valid && (state_q == sse_pkg::ST_LOAD);
    ram_we   = 1'b0;
    ram_addr = cnt_q[AB-1:0];

    cx    = ram_rdata[2*CB-1:CB];
    cy    = ram_rdata[CB-1:0];
    ex_n  = EB'(py_q) - EB'(cy);                       // left normal x
    ey_n  = EB'(cx) - EB'(px_q);                       // left normal y
    ex_l  = (EB'(lx_q) <<< 1) - EB'(px_q) - EB'(cx);   // 2*light - v0 - v1
    ey_l  = (EB'(ly_q) <<< 1) - EB'(py_q) - EB'(cy);
    dot   = (PB + 1)'(p1_q) + (PB + 1)'(p2_q);
    fnow  = !dot[PB] && (dot != '0);
    e     = AB'(idx_q - NC'(1));
    f0v   = (idx_q == NC'(1)) ? fnow : f0_q;
    sp    = '0;
    rem2  = {srem_q[RB:0], sv_q[2*RB-1 -: 2]};
    trial = {1'b0, root_q, 2'b01};
    drx   = {rx_q, nx_q[NB-1]};
    dry   = {ry_q, ny_q[NB-1]};
    bx    = (drx >= {1'b0, root_q});
    by    = (dry >= {1'b0, root_q});
    qsum  = (SB + 1)'(sqx_q) + (SB + 1)'(sqy_q);
    ox    = dx_q[DB-1] ? -$signed({1'b0, nx_q}) : $signed({1'b0, nx_q});
    oy    = dy_q[DB-1] ? -$signed({1'b0, ny_q}) : $signed({1'b0, ny_q});
    sx    = FB'(vx_q) + ox;
    sy    = FB'(vy_q) + oy;
    wnext = NC'(widx_q) + NC'(1);

    unique case (state_q)
      sse_pkg::ST_LOAD: begin
        if (acc) begin
          if (cnt_q < NC'(sse_pkg::MaxVertices)) begin
            ram_we = 1'b1;
            cnt_d  = cnt_q + NC'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (vtx_i.data.last_vertex) begin
            idx_d   = '0;
            found_d = '0;
            ent_d   = '0;
            ext_d   = '0;
            state_d = sse_pkg::ST_SCAN_RD;
          end
        end
      end
      sse_pkg::ST_SCAN_RD: begin
        // The closing edge ends at vertex 0.
        ram_addr = (idx_q == cnt_q) ? '0 : idx_q[AB-1:0];
        state_d  = sse_pkg::ST_SCAN_MUL;
      end
      sse_pkg::ST_SCAN_MUL: begin
        px_d = cx;
        py_d = cy;
        if (idx_q == '0) begin
          idx_d   = NC'(1);
          state_d = sse_pkg::ST_SCAN_RD;
        end else begin
          p1_d    = ex_n * ex_l;
          p2_d    = ey_n * ey_l;
          state_d = sse_pkg::ST_SCAN_SUM;
        end
      end
      sse_pkg::ST_SCAN_SUM: begin
        // Edge e just classified; a change between edges e-1 and e is at vertex e.
        if (idx_q == NC'(1)) begin
          f0_d = fnow;
        end else if (fnow != fprev_q) begin
          if (fnow) begin
            ent_d   = e;
            found_d = found_d | 2'b01;
          end else begin
            ext_d   = e;
            found_d = found_d | 2'b10;
          end
        end
        fprev_d = fnow;
        if (idx_q == cnt_q) begin
          // Wrap from the last edge to edge 0: change at vertex 0, found last.
          if (fnow != f0v) begin
            if (f0v) begin
              ent_d   = '0;
              found_d = found_d | 2'b01;
            end else begin
              ext_d   = '0;
              found_d = found_d | 2'b10;
            end
          end
          state_d = sse_pkg::ST_SPAN;
        end else begin
          idx_d   = idx_q + NC'(1);
          state_d = sse_pkg::ST_SCAN_RD;
        end
      end
      sse_pkg::ST_SPAN: begin
        if (found_q == 2'b11) begin
          sp = (NC + 1)'(ext_q) + (NC + 1)'(cnt_q) - (NC + 1)'(ent_q);
          if (sp >= (NC + 1)'(cnt_q)) begin
            sp = sp - (NC + 1)'(cnt_q);
          end
          span_d  = sp[AB-1:0];
          widx_d  = ent_q;
          k_d     = '0;
          state_d = sse_pkg::ST_WALK_RD;
        end else begin
          state_d = sse_pkg::ST_EMPTY;
        end
      end
      sse_pkg::ST_WALK_RD: begin
        ram_addr = widx_q;
        state_d  = sse_pkg::ST_WALK_D;
      end
      sse_pkg::ST_WALK_D: begin
        vx_d    = cx;
        vy_d    = cy;
        dx_d    = DB'(cx) - DB'(lx_q);
        dy_d    = DB'(cy) - DB'(ly_q);
        state_d = sse_pkg::ST_WALK_SQ;
      end
      sse_pkg::ST_WALK_SQ: begin
        sqx_d   = SB'(dx_q * dx_q);
        sqy_d   = SB'(dy_q * dy_q);
        mx_d    = (dx_q[DB-1] ? DB'(-dx_q) : DB'(dx_q)) * lr_q;
        my_d    = (dy_q[DB-1] ? DB'(-dy_q) : DB'(dy_q)) * lr_q;
        state_d = sse_pkg::ST_WALK_Q;
      end
      sse_pkg::ST_WALK_Q: begin
        if (qsum == '0) begin
          // Vertex on the light: far point is the vertex.
          fx_d    = vx_q;
          fy_d    = vy_q;
          clip_d  = 1'b0;
          state_d = sse_pkg::ST_PUT;
        end else begin
          sv_d    = (2 * RB)'({qsum, {(2 * sse_pkg::ScaleBits){1'b0}}});
          srem_d  = '0;
          root_d  = '0;
          it_d    = '0;
          state_d = sse_pkg::ST_SQRT;
        end
      end
      sse_pkg::ST_SQRT: begin
        sv_d = sv_q << 2;
        if (rem2 >= trial) begin
          srem_d = (RB + 1)'(rem2 - trial);
          root_d = {root_q[RB-2:0], 1'b1};
        end else begin
          srem_d = (RB + 1)'(rem2);
          root_d = {root_q[RB-2:0], 1'b0};
        end
        it_d = it_q + IB'(1);
        if (it_q == IB'(RB - 1)) begin
          state_d = sse_pkg::ST_DINIT;
        end
      end
      sse_pkg::ST_DINIT: begin
        // Rounded: add half the divisor, then divide.
        nx_d    = {1'b0, mx_q, {sse_pkg::ScaleBits{1'b0}}} + NB'(root_q >> 1);
        ny_d    = {1'b0, my_q, {sse_pkg::ScaleBits{1'b0}}} + NB'(root_q >> 1);
        rx_d    = '0;
        ry_d    = '0;
        it_d    = '0;
        state_d = sse_pkg::ST_DIV;
      end
      sse_pkg::ST_DIV: begin
        rx_d = bx ? RB'(drx - {1'b0, root_q}) : RB'(drx);
        ry_d = by ? RB'(dry - {1'b0, root_q}) : RB'(dry);
        nx_d = {nx_q[NB-2:0], bx};
        ny_d = {ny_q[NB-2:0], by};
        it_d = it_q + IB'(1);
        if (it_q == IB'(NB - 1)) begin
          state_d = sse_pkg::ST_FAR;
        end
      end
      sse_pkg::ST_FAR: begin
        clip_d = 1'b0;
        if (sx > CoordMax) begin
          fx_d = CB'(CoordMax);  clip_d = 1'b1;
        end else if (sx < CoordMin) begin
          fx_d = CB'(CoordMin);  clip_d = 1'b1;
        end else begin
          fx_d = CB'(sx);
        end
        if (sy > CoordMax) begin
          fy_d = CB'(CoordMax);  clip_d = 1'b1;
        end else if (sy < CoordMin) begin
          fy_d = CB'(CoordMin);  clip_d = 1'b1;
        end else begin
          fy_d = CB'(sy);
        end
        state_d = sse_pkg::ST_PUT;
      end
      sse_pkg::ST_PUT: begin
        if (put_ok) begin
          out_valid_d             = 1'b1;
          out_d.near_x            = vx_q;
          out_d.near_y            = vy_q;
          out_d.far_x             = fx_q;
          out_d.far_y             = fy_q;
          out_d.has_shadow        = 1'b1;
          out_d.far_clipped       = clip_q;
          out_d.too_many_vertices = ovf_q;
          out_d.last_pair         = (k_q == span_q);
          if (k_q == span_q) begin
            cnt_d   = '0;
            ovf_d   = 1'b0;
            state_d = sse_pkg::ST_LOAD;
          end else begin
            k_d     = k_q + AB'(1);
            widx_d  = (wnext == cnt_q) ? '0 : wnext[AB-1:0];
            state_d = sse_pkg::ST_WALK_RD;
          end
        end
      end
      sse_pkg::ST_EMPTY: begin
        if (put_ok) begin
          out_valid_d             = 1'b1;
          out_d                   = '0;
          out_d.too_many_vertices = ovf_q;
          out_d.last_pair         = 1'b1;
          cnt_d                   = '0;
          ovf_d                   = 1'b0;
          state_d                 = sse_pkg::ST_LOAD;
        end
      end
      default: state_d = sse_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sse_pkg::ST_LOAD;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      found_q     <= '0;
      ent_q       <= '0;
      ext_q       <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
      found_q     <= found_d;
      ent_q       <= ent_d;
      ext_q       <= ext_d;
    end
  end

  // Datapath registers, no reset.
  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;   px_q  <= px_d;   py_q  <= py_d;
    p1_q   <= p1_d;    p2_q  <= p2_d;
    f0_q   <= f0_d;    fprev_q <= fprev_d;
    widx_q <= widx_d;  k_q   <= k_d;    span_q <= span_d;
    vx_q   <= vx_d;    vy_q  <= vy_d;   dx_q  <= dx_d;  dy_q <= dy_d;
    sqx_q  <= sqx_d;   sqy_q <= sqy_d;
    sv_q   <= sv_d;    srem_q <= srem_d; root_q <= root_d; it_q <= it_d;
    mx_q   <= mx_d;    my_q  <= my_d;
    nx_q   <= nx_d;    ny_q  <= ny_d;   rx_q  <= rx_d;  ry_q <= ry_d;
    fx_q   <= fx_d;    fy_q  <= fy_d;   clip_q <= clip_d;
    out_q  <= out_d;
  end

endmodule

### design/sse_checker.sv
// Port-level checks of the shadow silhouette extruder, bound to its top level.
`include "shadow_silhouette_extruder_defines.svh"

module sse_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          vtx_valid_i,
  input logic          vtx_ready_i,
  input logic          vtx_last_i,
  input logic          res_valid_i,
  input logic          res_ready_i,
  input sse_pkg::res_t res_data_i
);
  // A stalled result beat holds.
  `SSE_ASSERT_NEXT(a_res_hold, res_valid_i && !res_ready_i, res_valid_i && $stable(res_data_i), "result beat changed while stalled")

  // The empty result beat is final, unclipped, with zero near_x and far_y.
  `SSE_ASSERT_NOW(a_empty_form, res_valid_i && !res_data_i.has_shadow, res_data_i.last_pair && !res_data_i.far_clipped && res_data_i.near_x == '0 && res_data_i.far_y == '0, "malformed empty result")

  // Closing a polygon stops input until the walk is done.
  `SSE_ASSERT_NEXT(a_busy_after_last, vtx_valid_i && vtx_ready_i && vtx_last_i, !vtx_ready_i, "vertex taken right after polygon close")

  // A clipped far point only comes with a silhouette beat.
  `SSE_ASSERT_NOW(a_clip_needs_shadow, res_valid_i && res_data_i.far_clipped, res_data_i.has_shadow, "clip flag on empty result")

endmodule

bind shadow_silhouette_extruder sse_checker u_sse_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .vtx_valid_i (vtx_i.valid),
  .vtx_ready_i (vtx_i.ready),
  .vtx_last_i  (vtx_i.data.last_vertex),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_data_i  (res_o.data)
);

### test/tb.sv
// Testbench for shadow_silhouette_extruder: polygons in, checked silhouette beats out.
module tb;

  localparam int NVtx      = 32;
  localparam int Watchdog  = 20000;
  localparam int HoldLen   = 3000;
  localparam int DrainWait = 200;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [sse_pkg::CfgIdxBits-1:0] cfg_idx_i = sse_pkg::CFG_LIGHT_X;
  logic [sse_pkg::CoordBits-1:0] cfg_data_i = '0;

  sse_vtx_if vtx_if ();
  sse_res_if res_if ();

  shadow_silhouette_extruder DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .vtx_i      (vtx_if),
    .res_o      (res_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Shadow copy of the block: light registers and the polygon being loaded.
  longint light_x, light_y, light_radius;
  longint poly_x[NVtx];
  longint poly_y[NVtx];
  int     poly_cnt;
  bit     poly_ovf;
  sse_pkg::res_t shadow_q[$];

  int     fail_cnt;
  int     idle_cycles = 0;
  int     hold_req_cnt;
  int     burst_left;
  int     sent_cnt;

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Signed offset d*radius/len, rounded half away from zero; len carries 8 extra bits.
  function automatic longint push_out(longint d, longint unsigned len);
    longint unsigned a, q;
    a = longint'(d < 0 ? -d : d) * longint'(light_radius) * 256;
    q = (a + len / 2) / len;
    return d < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clamp16(longint v, inout bit clip);
    if (v > 32767) begin
      clip = 1'b1;
      return 32767;
    end
    if (v < -32768) begin
      clip = 1'b1;
      return -32768;
    end
    return v;
  endfunction

  // Load one vertex; on the closing vertex compute the silhouette beats.
  function automatic void extrude_vertex(sse_pkg::vtx_t v);
    int n, j, span, idx;
    bit back[NVtx];
    bit got_in, got_out;
    int entry_k, exit_k;
    longint nx, ny, lx, ly, dx, dy, fx, fy;
    longint unsigned q, len;
    bit clip;
    sse_pkg::res_t r;
    if (poly_cnt < NVtx) begin
      poly_x[poly_cnt] = longint'(v.vertex_x);
      poly_y[poly_cnt] = longint'(v.vertex_y);
      poly_cnt++;
    end else begin
      poly_ovf = 1'b1;
    end
    if (!v.last_vertex) return;
    n = poly_cnt;
    for (int i = 0; i < n; i++) begin
      j = (i + 1) % n;
      nx = -(poly_y[j] - poly_y[i]);
      ny = poly_x[j] - poly_x[i];
      lx = 2 * light_x - poly_x[i] - poly_x[j];
      ly = 2 * light_y - poly_y[i] - poly_y[j];
      back[i] = (nx * lx + ny * ly) > 0;
    end
    got_in = 0; got_out = 0; entry_k = 0; exit_k = 0;
    for (int i = 0; i < n; i++) begin
      j = (i + 1) % n;
      if (back[i] != back[j]) begin
        if (back[j]) begin
          entry_k = j; got_in = 1;
        end else begin
          exit_k = j; got_out = 1;
        end
      end
    end
    if (!(got_in && got_out)) begin
      r = '0;
      r.too_many_vertices = poly_ovf;
      r.last_pair = 1'b1;
      shadow_q = {shadow_q, r};
    end else begin
      span = (exit_k + n - entry_k) % n;
      for (int k = 0; k <= span; k++) begin
        idx = (entry_k + k) % n;
        dx = poly_x[idx] - light_x;
        dy = poly_y[idx] - light_y;
        q = longint'(dx * dx) + longint'(dy * dy);
        fx = poly_x[idx];
        fy = poly_y[idx];
        clip = 1'b0;
        if (q != 0) begin
          len = root64(q << 16);
          fx = clamp16(poly_x[idx] + push_out(dx, len), clip);
          fy = clamp16(poly_y[idx] + push_out(dy, len), clip);
        end
        r.near_x = poly_x[idx][15:0];
        r.near_y = poly_y[idx][15:0];
        r.far_x = fx[15:0];
        r.far_y = fy[15:0];
        r.has_shadow = 1'b1;
        r.far_clipped = clip;
        r.too_many_vertices = poly_ovf;
        r.last_pair = (k == span);
        shadow_q = {shadow_q, r};
      end
    end
    poly_cnt = 0;
    poly_ovf = 1'b0;
  endfunction

  function automatic void cmp_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fail_cnt++;
    end
  endfunction

  // Result side: check every accepted beat, drive ready on its own stall pattern.
  initial begin
    int mode_left, hold_left, hold_ack;
    bit stall_mode;
    sse_pkg::res_t exp_r, got;
    res_if.ready = 1'b0;
    mode_left = 0; hold_left = 0; hold_ack = 0; stall_mode = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_if.valid && res_if.ready) begin
        got = res_if.data;
        if (shadow_q.size() == 0) begin
          $error("result beat with nothing expected");
          fail_cnt++;
        end else begin
          exp_r = shadow_q.pop_front();
          cmp_field("near_x", exp_r.near_x, got.near_x);
          cmp_field("near_y", exp_r.near_y, got.near_y);
          cmp_field("far_x", exp_r.far_x, got.far_x);
          cmp_field("far_y", exp_r.far_y, got.far_y);
          cmp_field("has_shadow", exp_r.has_shadow, got.has_shadow);
          cmp_field("far_clipped", exp_r.far_clipped, got.far_clipped);
          cmp_field("too_many_vertices", exp_r.too_many_vertices, got.too_many_vertices);
          cmp_field("last_pair", exp_r.last_pair, got.last_pair);
        end
      end
      if (hold_ack != hold_req_cnt) begin
        hold_ack++;
        hold_left = HoldLen;
      end
      if (mode_left == 0) begin
        mode_left = $urandom_range(16, 96);
        stall_mode = $urandom_range(0, 1);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= stall_mode ? ($urandom_range(0, 2) == 0) : 1'b1;
      end
    end
  end

  // Watchdog: too long with no beat on either side ends the run.
  always @(posedge clk_i) begin
    if ((vtx_if.valid && vtx_if.ready) || (res_if.valid && res_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > Watchdog) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Offer one vertex; gaps between random bursts. Called at a rising edge.
  task automatic send_vertex(logic [15:0] x, logic [15:0] y, bit last);
    sse_pkg::vtx_t v;
    v.vertex_x = x;
    v.vertex_y = y;
    v.last_vertex = last;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        vtx_if.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
    burst_left--;
    vtx_if.valid <= 1'b1;
    vtx_if.data <= v;
    do @(posedge clk_i); while (!vtx_if.ready);
    extrude_vertex(v);
    sent_cnt++;
  endtask

  // Stop offering and wait until every expected beat is back and the block is quiet.
  task automatic drain();
    vtx_if.valid <= 1'b0;
    while (shadow_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  // One register write; the caller drops the write enable after its last write.
  task automatic write_reg(sse_pkg::cfg_idx_e idx, logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      sse_pkg::CFG_LIGHT_X:      light_x = longint'(signed'(val));
      sse_pkg::CFG_LIGHT_Y:      light_y = longint'(signed'(val));
      sse_pkg::CFG_LIGHT_RADIUS: light_radius = longint'(val);
      default: ;
    endcase
  endtask

  task automatic set_light(logic [15:0] x, logic [15:0] y, logic [15:0] rad);
    write_reg(sse_pkg::CFG_LIGHT_X, x);
    write_reg(sse_pkg::CFG_LIGHT_Y, y);
    write_reg(sse_pkg::CFG_LIGHT_RADIUS, rad);
    cfg_we_i <= 1'b0;
  endtask

  // Hand-picked polygons: silhouette, no silhouette, lone vertex, vertex on light, saturation.
  task automatic test_directed();
    set_light(16'sd0, 16'sd0, 16'd160);
    send_vertex(16'sd320, 16'sd320, 0);
    send_vertex(16'sd480, 16'sd320, 0);
    send_vertex(16'sd320, 16'sd480, 1);
    send_vertex(16'sd100, 16'sd100, 1);            // lone vertex, empty result
    send_vertex(-16'sd160, -16'sd160, 0);          // light inside the square
    send_vertex(16'sd160, -16'sd160, 0);
    send_vertex(16'sd160, 16'sd160, 0);
    send_vertex(-16'sd160, 16'sd160, 1);
    send_vertex(16'sd0, 16'sd0, 0);                // one corner on the light
    send_vertex(16'sd800, -16'sd400, 0);
    send_vertex(16'sd800, 16'sd400, 1);
    drain();
    // Extreme light and radius push far points into saturation.
    set_light(16'h8000, 16'h7fff, 16'hffff);
    send_vertex(16'h7fff, 16'h7fff, 0);
    send_vertex(16'h8000, 16'h8000, 0);
    send_vertex(16'h7fff, 16'h8000, 1);
    drain();
    set_light(16'h7fff, 16'h8000, 16'd0);
    send_vertex(16'h8000, 16'h7fff, 0);
    send_vertex(16'h0000, 16'h0000, 0);
    send_vertex(16'h7fff, 16'h7fff, 1);
    drain();
  endtask

  function automatic logic [15:0] pick_coord(bit wide);
    return wide ? 16'($urandom) : 16'(int'($urandom_range(0, 1200)) - 600);
  endfunction

  task automatic send_polygon(int n, bit wide);
    for (int i = 0; i < n; i++)
      send_vertex(pick_coord(wide), pick_coord(wide), i == n - 1);
  endtask

  // Random polygons under a few light settings, one overflowing the store.
  task automatic test_random();
    int phase_items;
    for (int ph = 0; ph < 3; ph++) begin
      set_light(pick_coord($urandom_range(0, 1)), pick_coord($urandom_range(0, 1)),
                ph == 0 ? 16'($urandom) : 16'($urandom_range(0, 800)));
      phase_items = sent_cnt + 12;
      while (sent_cnt < phase_items)
        send_polygon($urandom_range(1, 7), $urandom_range(0, 3) == 0);
      drain();
    end
    send_polygon($urandom_range(33, 35), 0);       // more than the store holds
    drain();
  endtask

  // Long receiver hold while polygons keep coming, so the input backs up.
  task automatic test_backpressure();
    set_light(16'sd40, -16'sd24, 16'd400);
    hold_req_cnt++;
    for (int p = 0; p < 4; p++)
      send_polygon($urandom_range(3, 5), 0);
    drain();
  endtask

  initial begin
    vtx_if.valid = 1'b0;
    vtx_if.data = '0;
    light_x = 0; light_y = 0; light_radius = 0;
    poly_cnt = 0; poly_ovf = 0;
    fail_cnt = 0; hold_req_cnt = 0; burst_left = 0; sent_cnt = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random();
    test_backpressure();
    if (fail_cnt == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
